// ----- rtl/core/mrru_pkg.sv -----
// Shared types, codes and sizing constants for the matrix register rename unit.
package mrru_pkg;

  localparam int TILE_REGS    = 16;
  localparam int PHYS_REGS    = 32;
  localparam int LOGICAL_REGS = 8;
  localparam int ACC_CAP      = PHYS_REGS - TILE_REGS;

  localparam int PHYS_W  = 5;
  localparam int LOG_W   = 3;
  localparam int CNT_W   = 5;
  localparam int LOCK_W  = 4;
  localparam int REL_N   = 4;

  localparam int QDEPTH  = (TILE_REGS > ACC_CAP) ? TILE_REGS : ACC_CAP;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Accumulator queue starts with the registers above the four that reset maps.
  localparam int ACC_INIT_FIRST = TILE_REGS + 4;
  localparam int ACC_INIT_N     = ACC_CAP - 4;
  localparam int ACC_INIT_TAIL  = (ACC_INIT_N == ACC_CAP) ? 0 : ACC_INIT_N;

  localparam logic [LOCK_W-1:0] LOCK_MAX = '1;

  typedef enum logic [3:0] {
    K_ALLOC_TILE  = 4'd0,
    K_ALLOC_ACC   = 4'd1,
    K_FREE        = 4'd2,
    K_READ_MAP    = 4'd3,
    K_WRITE_MAP   = 4'd4,
    K_SET_READY   = 4'd5,
    K_GET_READY   = 4'd6,
    K_LOCK        = 4'd7,
    K_UNLOCK      = 4'd8,
    K_CHECK_LOCK  = 4'd9,
    K_SET_RELEASE = 4'd10,
    K_GET_RELEASE = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_UNDER  = 3'd3,
    ST_SAT    = 3'd4,
    ST_NOTACC = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0]        kind;
    logic [LOG_W-1:0]  log_reg;
    logic [PHYS_W-1:0] phys_reg;
    logic              flag_in;
  } item_t;

  typedef struct packed {
    logic  fire;
    item_t item;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PHYS_W-1:0] phys;
    logic              unmapped;
    logic              flag;
  } tbl_res_t;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [PHYS_W-1:0] data;
  } q_ctrl_t;

  typedef struct packed {
    logic [PHYS_W-1:0] head;
    logic [QCNT_W-1:0] count;
    logic [QCNT_W-1:0] count_nxt;
  } q_stat_t;

endpackage

// ----- rtl/core/mrru_free_queue.sv -----
// Circular free queue of physical register indexes with reset contents from ports.
module mrru_free_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mrru_pkg::QCNT_W-1:0]   cap,
  input  logic [mrru_pkg::PHYS_W-1:0]   init_first,
  input  logic [mrru_pkg::QCNT_W-1:0]   init_count,
  input  logic [mrru_pkg::QIDX_W-1:0]   init_tail,
  input  mrru_pkg::q_ctrl_t             ctrl,
  output mrru_pkg::q_stat_t             stat
);

  logic [mrru_pkg::PHYS_W-1:0] q_r [mrru_pkg::QDEPTH];
  logic [mrru_pkg::QIDX_W-1:0] head_r, head_nxt;
  logic [mrru_pkg::QIDX_W-1:0] tail_r, tail_nxt;
  logic [mrru_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic [mrru_pkg::QIDX_W-1:0] last_idx;

  assign last_idx = mrru_pkg::QIDX_W'(cap - 1'b1);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctrl.pop) begin
      head_nxt  = (head_r == last_idx) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (ctrl.push) begin
      tail_nxt  = (tail_r == last_idx) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= init_tail;
      count_r <= init_count;
      for (int i = 0; i < mrru_pkg::QDEPTH; i++) begin
        q_r[i] <= (i < int'(init_count)) ?
                  mrru_pkg::PHYS_W'(int'(init_first) + i) : '0;
      end
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (ctrl.push) begin
        q_r[tail_r] <= ctrl.data;
      end
    end
  end

  assign stat.head      = q_r[head_r];
  assign stat.count     = count_r;
  assign stat.count_nxt = count_nxt;

endmodule

// ----- rtl/core/mrru_tables.sv -----
// Map table, ready bits, lock counters and release flags with their request handling.
module mrru_tables (
  input  logic               clk,
  input  logic               rst_n,
  input  mrru_pkg::req_t     req,
  output mrru_pkg::tbl_res_t res
);

  logic [mrru_pkg::PHYS_W-1:0] map_r   [mrru_pkg::LOGICAL_REGS];
  logic                        mval_r  [mrru_pkg::LOGICAL_REGS];
  logic                        ready_r [mrru_pkg::PHYS_REGS];
  logic [mrru_pkg::LOCK_W-1:0] lock_r  [mrru_pkg::PHYS_REGS];
  logic                        rel_r   [mrru_pkg::REL_N];

  logic [mrru_pkg::PHYS_W-1:0] pr;
  logic [mrru_pkg::LOG_W-1:0]  lr;
  logic                        pin;
  logic                        is_acc;
  logic [1:0]                  rel_idx;
  logic [mrru_pkg::LOCK_W-1:0] lock_cur;

  logic                        map_we;
  logic                        ready_we;
  logic                        ready_val;
  logic                        lock_we;
  logic [mrru_pkg::LOCK_W-1:0] lock_val;
  logic                        rel_we;
  logic                        rel_val;

  assign pr       = req.item.phys_reg;
  assign lr       = req.item.log_reg;
  assign pin      = {3'b000, pr} < 8'(mrru_pkg::PHYS_REGS);
  assign is_acc   = lr[2];
  assign rel_idx  = lr[1:0];
  assign lock_cur = lock_r[pr];

  always_comb begin
    res.status   = mrru_pkg::ST_OK;
    res.phys     = '0;
    res.unmapped = 1'b0;
    res.flag     = 1'b0;
    map_we       = 1'b0;
    ready_we     = 1'b0;
    ready_val    = 1'b0;
    lock_we      = 1'b0;
    lock_val     = lock_cur;
    rel_we       = 1'b0;
    rel_val      = 1'b0;
    unique case (mrru_pkg::kind_t'(req.item.kind))
      mrru_pkg::K_READ_MAP: begin
        if (mval_r[lr]) begin
          res.phys = map_r[lr];
        end else begin
          res.unmapped = 1'b1;
        end
      end
      mrru_pkg::K_WRITE_MAP: begin
        map_we   = 1'b1;
        ready_we = pin;
        rel_we   = is_acc;
      end
      mrru_pkg::K_SET_READY: begin
        ready_we  = pin;
        ready_val = req.item.flag_in;
      end
      mrru_pkg::K_GET_READY: begin
        res.flag = pin && ready_r[pr];
      end
      mrru_pkg::K_LOCK: begin
        if (pin) begin
          if (lock_cur == mrru_pkg::LOCK_MAX) begin
            res.status = mrru_pkg::ST_SAT;
          end else begin
            lock_we  = 1'b1;
            lock_val = lock_cur + 1'b1;
          end
        end
      end
      mrru_pkg::K_UNLOCK: begin
        if (pin) begin
          if (lock_cur == '0) begin
            res.status = mrru_pkg::ST_UNDER;
          end else begin
            lock_we  = 1'b1;
            lock_val = lock_cur - 1'b1;
          end
        end
      end
      mrru_pkg::K_CHECK_LOCK: begin
        res.flag = pin && (lock_cur != '0);
      end
      mrru_pkg::K_SET_RELEASE: begin
        if (!is_acc) begin
          res.status = mrru_pkg::ST_NOTACC;
        end else begin
          rel_we  = 1'b1;
          rel_val = req.item.flag_in;
        end
      end
      mrru_pkg::K_GET_RELEASE: begin
        if (!is_acc) begin
          res.status = mrru_pkg::ST_NOTACC;
        end else begin
          res.flag = rel_r[rel_idx];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mrru_pkg::LOGICAL_REGS; i++) begin
        map_r[i]  <= (i >= 4) ? mrru_pkg::PHYS_W'(mrru_pkg::TILE_REGS + i - 4) : '0;
        mval_r[i] <= (i >= 4);
      end
      for (int i = 0; i < mrru_pkg::PHYS_REGS; i++) begin
        ready_r[i] <= 1'b0;
        lock_r[i]  <= '0;
      end
      for (int i = 0; i < mrru_pkg::REL_N; i++) begin
        rel_r[i] <= 1'b0;
      end
    end else if (req.fire) begin
      if (map_we) begin
        map_r[lr]  <= pr;
        mval_r[lr] <= 1'b1;
      end
      if (ready_we) begin
        ready_r[pr] <= ready_val;
      end
      if (lock_we) begin
        lock_r[pr] <= lock_val;
      end
      if (rel_we) begin
        rel_r[rel_idx] <= rel_val;
      end
    end
  end

endmodule

// ----- rtl/core/matrix_register_rename_unit_top.sv -----
// Top level of the matrix register rename unit: handshake stages, queue control, result.
//
// channel | dir | handshake                        | payload
// in_     | in  | in_tvalid / in_tready            | in_tuser kind, in_tdata request
// out_    | out | out_tvalid / out_tready          | out_tdata result and queue counts
//
// One item per cycle sustained while out_tready stays high.
// The request register feeds one pass through the queues and tables into the result register.
// Synchronous active-low reset restores queues, map, ready, lock and release state at once.
// A stalled result holds its item in the request register; in_tready drops only then.
module matrix_register_rename_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,   // [3:0] kind
  input  logic [15:0] in_tdata,   // [2:0] log_reg, [7:3] phys_reg, [8] flag_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] status, [7:3] phys_out, [8] unmapped,
                                  // [9] flag_out, [14:10] tile_free_count,
                                  // [19:15] acc_free_count
);

  logic              s1_valid_r;
  mrru_pkg::item_t   s1_item_r;
  logic              adv;
  logic              fire;
  mrru_pkg::req_t    req;
  mrru_pkg::tbl_res_t tres;

  mrru_pkg::q_ctrl_t tq_ctrl, aq_ctrl;
  mrru_pkg::q_stat_t tq_stat, aq_stat;

  mrru_pkg::status_t           status_nxt;
  logic [mrru_pkg::PHYS_W-1:0] phys_nxt;
  logic                        pin;
  logic                        is_tile;

  logic                        out_valid_r;
  logic [23:0]                 out_data_r;

  assign adv       = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.kind     <= in_tuser;
      s1_item_r.log_reg  <= in_tdata[2:0];
      s1_item_r.phys_reg <= in_tdata[7:3];
      s1_item_r.flag_in  <= in_tdata[8];
    end
  end

  assign req.fire = fire;
  assign req.item = s1_item_r;

  assign pin     = {3'b000, s1_item_r.phys_reg} < 8'(mrru_pkg::PHYS_REGS);
  assign is_tile = {3'b000, s1_item_r.phys_reg} < 8'(mrru_pkg::TILE_REGS);

  // Queue side of the request; the table side comes back from mrru_tables.
  always_comb begin
    tq_ctrl      = '0;
    aq_ctrl      = '0;
    tq_ctrl.data = s1_item_r.phys_reg;
    aq_ctrl.data = s1_item_r.phys_reg;
    status_nxt   = tres.status;
    phys_nxt     = tres.phys;
    unique case (mrru_pkg::kind_t'(s1_item_r.kind))
      mrru_pkg::K_ALLOC_TILE: begin
        if (tq_stat.count == '0) begin
          status_nxt = mrru_pkg::ST_EMPTY;
        end else begin
          tq_ctrl.pop = fire;
          phys_nxt    = tq_stat.head;
        end
      end
      mrru_pkg::K_ALLOC_ACC: begin
        if (aq_stat.count == '0) begin
          status_nxt = mrru_pkg::ST_EMPTY;
        end else begin
          aq_ctrl.pop = fire;
          phys_nxt    = aq_stat.head;
        end
      end
      mrru_pkg::K_FREE: begin
        if (is_tile) begin
          if (tq_stat.count >= mrru_pkg::QCNT_W'(mrru_pkg::TILE_REGS)) begin
            status_nxt = mrru_pkg::ST_FULL;
          end else begin
            tq_ctrl.push = fire;
          end
        end else if (pin) begin
          if (aq_stat.count >= mrru_pkg::QCNT_W'(mrru_pkg::ACC_CAP)) begin
            status_nxt = mrru_pkg::ST_FULL;
          end else begin
            aq_ctrl.push = fire;
          end
        end
      end
      default: begin
      end
    endcase
  end

  mrru_free_queue u_tile_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap        (mrru_pkg::QCNT_W'(mrru_pkg::TILE_REGS)),
    .init_first ('0),
    .init_count (mrru_pkg::QCNT_W'(mrru_pkg::TILE_REGS)),
    .init_tail  ('0),
    .ctrl       (tq_ctrl),
    .stat       (tq_stat)
  );

  mrru_free_queue u_acc_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap        (mrru_pkg::QCNT_W'(mrru_pkg::ACC_CAP)),
    .init_first (mrru_pkg::PHYS_W'(mrru_pkg::ACC_INIT_FIRST)),
    .init_count (mrru_pkg::QCNT_W'(mrru_pkg::ACC_INIT_N)),
    .init_tail  (mrru_pkg::QIDX_W'(mrru_pkg::ACC_INIT_TAIL)),
    .ctrl       (aq_ctrl),
    .stat       (aq_stat)
  );

  mrru_tables u_tables (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (tres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {4'b0000,
                     mrru_pkg::CNT_W'(aq_stat.count_nxt),
                     mrru_pkg::CNT_W'(tq_stat.count_nxt),
                     tres.flag,
                     tres.unmapped,
                     phys_nxt,
                     status_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("request register changed while stalled");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(tq_ctrl.pop && tq_stat.count == '0) && !(aq_ctrl.pop && aq_stat.count == '0))
    else $error("pop from empty free queue");

  a_tile_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tq_stat.count <= mrru_pkg::QCNT_W'(mrru_pkg::TILE_REGS))
    else $error("tile free queue over capacity");

  a_full_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_item_r.kind != mrru_pkg::K_FREE |-> status_nxt != mrru_pkg::ST_FULL)
    else $error("full status outside free request");

  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    tq_ctrl.pop |=> tq_stat.count == $past(tq_stat.count) - 1'b1)
    else $error("tile queue count not decremented on pop");
`endif

endmodule

// ----- tb/matrix_register_rename_unit_top_tb.sv -----
// Self-checking testbench for the matrix register rename unit: directed table, then random items.
`timescale 1ns / 1ps

module matrix_register_rename_unit_top_tb;

  localparam int          IDLE_LIMIT = 2000;
  localparam int          LOCK_TOP   = 15;
  localparam int          RAND_ITEMS = 1200;
  localparam int          BLOCK_LEN  = 40;
  localparam int          HOLD_AT    = 400;
  localparam int          HOLD_LEN   = 300;
  localparam logic [3:0]  K_SPARE_LO = 4'd12;
  localparam logic [3:0]  K_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] lr;
    logic [4:0] phys;
    logic       flag;
  } rename_req_t;

  typedef struct packed {
    mrru_pkg::status_t status;
    logic [4:0]        phys;
    logic              unm;
    logic              flag;
    logic [4:0]        tcnt;
    logic [4:0]        acnt;
  } rename_res_t;

  typedef struct packed {
    rename_req_t req;
    logic        typed;
    rename_res_t res;
  } plan_row_t;

  typedef enum int {MODE_MIX, MODE_DRAIN, MODE_FILL, MODE_LOCKS, MODE_RENAME} mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [3:0]  in_tuser;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  matrix_register_rename_unit_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predicted rename state
  logic [4:0] tile_fifo [mrru_pkg::TILE_REGS];
  logic [4:0] acc_fifo  [mrru_pkg::ACC_CAP];
  int         tile_head, tile_tail, tile_cnt;
  int         acc_head, acc_tail, acc_cnt;
  logic [4:0] map_phys  [8];
  logic       map_ok    [8];
  logic       ready_bit [mrru_pkg::PHYS_REGS];
  int         lock_cnt  [mrru_pkg::PHYS_REGS];
  logic       rel_flag  [4];

  rename_res_t pending_res[$];
  rename_res_t last_res;
  rename_res_t want_res;
  plan_row_t   plan[$];
  int          items_sent, results_seen, renames_done, fails, idle_cycles;
  int          status_seen[8];
  logic        src_burst, sink_burst;

  function automatic void reset_model();
    for (int i = 0; i < mrru_pkg::TILE_REGS; i++) tile_fifo[i] = 5'(i);
    for (int i = 0; i < mrru_pkg::ACC_CAP; i++) acc_fifo[i] = '0;
    acc_cnt = 0;
    for (int i = mrru_pkg::TILE_REGS + 4; i < mrru_pkg::PHYS_REGS; i++) begin
      acc_fifo[acc_cnt] = 5'(i);
      acc_cnt++;
    end
    tile_head = 0;
    tile_tail = 0;
    tile_cnt  = mrru_pkg::TILE_REGS;
    acc_head  = 0;
    acc_tail  = acc_cnt % mrru_pkg::ACC_CAP;
    for (int i = 0; i < 8; i++) begin
      map_phys[i] = (i >= 4) ? 5'(mrru_pkg::TILE_REGS + i - 4) : '0;
      map_ok[i]   = (i >= 4);
    end
    for (int i = 0; i < mrru_pkg::PHYS_REGS; i++) begin
      ready_bit[i] = 1'b0;
      lock_cnt[i]  = 0;
    end
    for (int i = 0; i < 4; i++) rel_flag[i] = 1'b0;
  endfunction

  function automatic rename_res_t rename_predict(rename_req_t rq);
    rename_res_t r;
    logic        in_range;
    int          p;
    r        = '0;
    p        = int'(rq.phys);
    in_range = (p < mrru_pkg::PHYS_REGS);
    case (rq.kind)
      mrru_pkg::K_ALLOC_TILE: begin
        if (tile_cnt == 0) begin
          r.status = mrru_pkg::ST_EMPTY;
        end else begin
          r.phys    = tile_fifo[tile_head];
          tile_head = (tile_head + 1) % mrru_pkg::TILE_REGS;
          tile_cnt--;
        end
      end
      mrru_pkg::K_ALLOC_ACC: begin
        if (acc_cnt == 0) begin
          r.status = mrru_pkg::ST_EMPTY;
        end else begin
          r.phys   = acc_fifo[acc_head];
          acc_head = (acc_head + 1) % mrru_pkg::ACC_CAP;
          acc_cnt--;
        end
      end
      mrru_pkg::K_FREE: begin
        if (p < mrru_pkg::TILE_REGS) begin
          if (tile_cnt >= mrru_pkg::TILE_REGS) begin
            r.status = mrru_pkg::ST_FULL;
          end else begin
            tile_fifo[tile_tail] = rq.phys;
            tile_tail = (tile_tail + 1) % mrru_pkg::TILE_REGS;
            tile_cnt++;
          end
        end else if (in_range) begin
          if (acc_cnt >= mrru_pkg::ACC_CAP) begin
            r.status = mrru_pkg::ST_FULL;
          end else begin
            acc_fifo[acc_tail] = rq.phys;
            acc_tail = (acc_tail + 1) % mrru_pkg::ACC_CAP;
            acc_cnt++;
          end
        end
      end
      mrru_pkg::K_READ_MAP: begin
        if (map_ok[rq.lr]) r.phys = map_phys[rq.lr];
        else r.unm = 1'b1;
      end
      mrru_pkg::K_WRITE_MAP: begin
        map_phys[rq.lr] = rq.phys;
        map_ok[rq.lr]   = 1'b1;
        if (in_range) ready_bit[p] = 1'b0;
        if (rq.lr >= 4) rel_flag[rq.lr - 4] = 1'b0;
      end
      mrru_pkg::K_SET_READY: begin
        if (in_range) ready_bit[p] = rq.flag;
      end
      mrru_pkg::K_GET_READY: r.flag = in_range && ready_bit[p];
      mrru_pkg::K_LOCK: begin
        if (in_range) begin
          if (lock_cnt[p] >= LOCK_TOP) r.status = mrru_pkg::ST_SAT;
          else lock_cnt[p]++;
        end
      end
      mrru_pkg::K_UNLOCK: begin
        if (in_range) begin
          if (lock_cnt[p] == 0) r.status = mrru_pkg::ST_UNDER;
          else lock_cnt[p]--;
        end
      end
      mrru_pkg::K_CHECK_LOCK: r.flag = in_range && (lock_cnt[p] > 0);
      mrru_pkg::K_SET_RELEASE: begin
        if (rq.lr < 4) r.status = mrru_pkg::ST_NOTACC;
        else rel_flag[rq.lr - 4] = rq.flag;
      end
      mrru_pkg::K_GET_RELEASE: begin
        if (rq.lr < 4) r.status = mrru_pkg::ST_NOTACC;
        else r.flag = rel_flag[rq.lr - 4];
      end
      default: ;
    endcase
    r.tcnt = 5'(tile_cnt);
    r.acnt = 5'(acc_cnt);
    return r;
  endfunction

  function automatic plan_row_t row(logic [3:0] kind, int lr, int phys, bit flag, bit typed,
                                    mrru_pkg::status_t st, int ph, bit unm, bit fo, int tc,
                                    int ac);
    plan_row_t t;
    t.req   = '{kind: kind, lr: 3'(lr), phys: 5'(phys), flag: flag};
    t.typed = typed;
    t.res   = '{status: st, phys: 5'(ph), unm: unm, flag: fo, tcnt: 5'(tc), acnt: 5'(ac)};
    return t;
  endfunction

  function automatic int draw_wait(logic burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // Offer one item and hold it until taken; the prediction runs at the accepting edge.
  task automatic offer_item(rename_req_t rq, logic typed, rename_res_t typed_res);
    int gap;
    if (items_sent % 64 == 0) src_burst = ($urandom_range(0, 3) == 0);
    gap = draw_wait(src_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq.kind;
    in_tdata  <= {7'd0, rq.flag, rq.phys, rq.lr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    last_res = rename_predict(rq);
    pending_res = {pending_res, (typed ? typed_res : last_res)};
    items_sent++;
  endtask

  task automatic offer(logic [3:0] kind, logic [2:0] lr, logic [4:0] phys, logic flag);
    offer_item('{kind: kind, lr: lr, phys: phys, flag: flag}, 1'b0, '0);
  endtask

  // Well-formed rename: allocate, map, mostly mark ready, set release for accumulators, then return the old mapping.
  task automatic rename_once();
    logic [2:0] lr;
    logic       had_map;
    logic [4:0] prev_phys;
    logic [4:0] fresh;
    lr        = 3'($urandom_range(0, 7));
    had_map   = map_ok[lr];
    prev_phys = map_phys[lr];
    offer((lr < 4) ? mrru_pkg::K_ALLOC_TILE : mrru_pkg::K_ALLOC_ACC, lr, 5'($urandom),
          1'($urandom));
    if (last_res.status == mrru_pkg::ST_OK) begin
      fresh = last_res.phys;
      offer(mrru_pkg::K_WRITE_MAP, lr, fresh, 1'($urandom));
      if ($urandom_range(0, 3) != 0) offer(mrru_pkg::K_SET_READY, lr, fresh, 1'b1);
      if (lr >= 4) offer(mrru_pkg::K_SET_RELEASE, lr, fresh, 1'($urandom));
      if (had_map) offer(mrru_pkg::K_FREE, lr, prev_phys, 1'($urandom));
      renames_done++;
    end
  endtask

  task automatic random_item(mode_t mode);
    rename_req_t rq;
    int          pct;
    pct     = $urandom_range(0, 99);
    rq.kind = 4'($urandom_range(0, 15));
    rq.lr   = 3'($urandom_range(0, 7));
    rq.phys = 5'($urandom_range(0, 31));
    rq.flag = 1'($urandom);
    case (mode)
      MODE_DRAIN: begin
        if (pct < 80) begin
          rq.kind = $urandom_range(0, 1) ? mrru_pkg::K_ALLOC_ACC : mrru_pkg::K_ALLOC_TILE;
        end
      end
      MODE_FILL:  if (pct < 75) rq.kind = mrru_pkg::K_FREE;
      MODE_LOCKS: begin
        rq.phys = 5'($urandom_range(0, 1)) | (($urandom_range(0, 1)) ? 5'd30 : 5'd0);
        if (pct < 70) rq.kind = mrru_pkg::K_LOCK;
        else if (pct < 85) rq.kind = mrru_pkg::K_UNLOCK;
        else if (pct < 95) rq.kind = mrru_pkg::K_CHECK_LOCK;
      end
      default: ;
    endcase
    offer_item(rq, 1'b0, '0);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      status_seen[out_tdata[2:0]]++;
      if (pending_res.size() == 0) begin
        $error("result with nothing pending: out_tdata=%h", out_tdata);
        fails++;
      end else begin
        want_res = pending_res[0];
        pending_res.delete(0);
        check_field("status", want_res.status, out_tdata[2:0]);
        check_field("phys_out", want_res.phys, out_tdata[7:3]);
        check_field("unmapped", want_res.unm, out_tdata[8]);
        check_field("flag_out", want_res.flag, out_tdata[9]);
        check_field("tile_free_count", want_res.tcnt, out_tdata[14:10]);
        check_field("acc_free_count", want_res.acnt, out_tdata[19:15]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("matrix_register_rename_unit_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink, with one long hold-off so the block backs up into its input
  initial begin : result_sink
    int stall;
    int n_taken;
    n_taken    = 0;
    sink_burst = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (n_taken % 64 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      stall = (n_taken == HOLD_AT) ? HOLD_LEN : draw_wait(sink_burst);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      n_taken++;
    end
  end

  initial begin : stimulus
    mode_t mode;
    int    block_end;
    int    pick;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = '0;
    in_tdata     = '0;
    src_burst    = 1'b0;
    items_sent   = 0;
    results_seen = 0;
    renames_done = 0;
    fails        = 0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    reset_model();

    // reset state, boundaries and the full, underflow and not-accumulator codes
    plan = {plan, row(mrru_pkg::K_READ_MAP,    0,  0, 0, 1, mrru_pkg::ST_OK,     0, 1, 0, 16, 12)};
    plan = {plan, row(mrru_pkg::K_READ_MAP,    7,  0, 0, 1, mrru_pkg::ST_OK,    19, 0, 0, 16, 12)};
    plan = {plan, row(mrru_pkg::K_FREE,        0,  3, 0, 1, mrru_pkg::ST_FULL,   0, 0, 0, 16, 12)};
    plan = {plan, row(mrru_pkg::K_ALLOC_TILE,  0,  0, 0, 1, mrru_pkg::ST_OK,     0, 0, 0, 15, 12)};
    plan = {plan, row(mrru_pkg::K_ALLOC_ACC,   4, 31, 1, 1, mrru_pkg::ST_OK,    20, 0, 0, 15, 11)};
    plan = {plan, row(mrru_pkg::K_FREE,        0, 16, 0, 1, mrru_pkg::ST_OK,     0, 0, 0, 15, 12)};
    // double free
    plan = {plan, row(mrru_pkg::K_FREE,        7, 31, 1, 1, mrru_pkg::ST_OK,     0, 0, 0, 15, 13)};
    plan = {plan, row(mrru_pkg::K_FREE,        0,  0, 0, 1, mrru_pkg::ST_OK,     0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_UNLOCK,      0,  5, 0, 1, mrru_pkg::ST_UNDER,  0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_LOCK,        0, 31, 0, 1, mrru_pkg::ST_OK,     0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_CHECK_LOCK,  0, 31, 0, 1, mrru_pkg::ST_OK,     0, 0, 1, 16, 13)};
    plan = {plan, row(mrru_pkg::K_CHECK_LOCK,  0,  0, 0, 1, mrru_pkg::ST_OK,     0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_SET_RELEASE, 3,  0, 1, 1, mrru_pkg::ST_NOTACC, 0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_GET_RELEASE, 0,  0, 0, 1, mrru_pkg::ST_NOTACC, 0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_SET_RELEASE, 7,  0, 1, 1, mrru_pkg::ST_OK,     0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_GET_RELEASE, 7,  0, 0, 1, mrru_pkg::ST_OK,     0, 0, 1, 16, 13)};
    plan = {plan, row(mrru_pkg::K_WRITE_MAP,   7, 31, 0, 1, mrru_pkg::ST_OK,     0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_GET_RELEASE, 7,  0, 0, 1, mrru_pkg::ST_OK,     0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_SET_READY,   0, 31, 1, 1, mrru_pkg::ST_OK,     0, 0, 0, 16, 13)};
    plan = {plan, row(mrru_pkg::K_GET_READY,   0, 31, 0, 1, mrru_pkg::ST_OK,     0, 0, 1, 16, 13)};
    plan = {plan, row(mrru_pkg::K_WRITE_MAP,   0, 20, 1, 0, mrru_pkg::ST_OK,     0, 0, 0,  0,  0)};
    plan = {plan, row(mrru_pkg::K_READ_MAP,    0,  0, 0, 0, mrru_pkg::ST_OK,     0, 0, 0,  0,  0)};
    plan = {plan, row(mrru_pkg::K_GET_READY,   0, 20, 0, 0, mrru_pkg::ST_OK,     0, 0, 0,  0,  0)};
    plan = {plan, row(K_SPARE_HI,              7, 31, 1, 1, mrru_pkg::ST_OK,     0, 0, 0, 16, 13)};
    plan = {plan, row(K_SPARE_LO,              0,  0, 0, 0, mrru_pkg::ST_OK,     0, 0, 0,  0,  0)};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) offer_item(plan[i].req, plan[i].typed, plan[i].res);

    // random part in blocks, each but the mixed ones biased toward one corner of the state
    while (items_sent < plan.size() + RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) mode = MODE_RENAME;
      else if (pick < 60) mode = MODE_MIX;
      else if (pick < 72) mode = MODE_DRAIN;
      else if (pick < 84) mode = MODE_FILL;
      else mode = MODE_LOCKS;
      block_end = items_sent + BLOCK_LEN;
      while (items_sent < block_end) begin
        if (mode == MODE_RENAME && $urandom_range(0, 9) != 0) rename_once();
        else random_item(mode);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d items, %0d results checked, %0d full renames", items_sent, results_seen,
             renames_done);
    $display("status hits: empty %0d, full %0d, underflow %0d, saturated %0d, not acc %0d",
             status_seen[mrru_pkg::ST_EMPTY], status_seen[mrru_pkg::ST_FULL],
             status_seen[mrru_pkg::ST_UNDER], status_seen[mrru_pkg::ST_SAT],
             status_seen[mrru_pkg::ST_NOTACC]);
    if (fails == 0 && pending_res.size() == 0) begin
      $display("matrix_register_rename_unit_top: match");
    end else begin
      $display("matrix_register_rename_unit_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mrru_pkg.sv
rtl/core/mrru_free_queue.sv
rtl/core/mrru_tables.sv
rtl/core/matrix_register_rename_unit_top.sv
tb/matrix_register_rename_unit_top_tb.sv
